>>> design/plg_pkg.sv
// ----------------------------------------------------------------------------
// plg_pkg: shared types and constants for the peak limiter gain stage
// Sequencer states, serial step counts, register map and fixed result codes.
// ----------------------------------------------------------------------------
package plg_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } state_t;

  // one coefficient bit / one quotient bit per step
  localparam int unsigned STEPS = 16;
  localparam int unsigned CNT_W = 4;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ATTACK    = 2'd1;
  localparam logic [1:0] REG_RELEASE   = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd32768;
  localparam logic [15:0] ATTACK_RST    = 16'd58982;
  localparam logic [15:0] RELEASE_RST   = 16'd66;

  localparam logic [15:0] DIV_UNITY = 16'd256;
  localparam logic [15:0] DIV_SAT   = 16'hFFFF;

endpackage

>>> design/peak_limiter_gain_top.sv
// ----------------------------------------------------------------------------
// peak_limiter_gain_top: per-channel peak limiter envelope and gain divisor
// Rectify, one-pole envelope update per channel, then env/threshold in Q8.8 (unity below threshold, FFFF on overflow).
// Words are handled one at a time: the 16-step serial multiplier, then, when
// limiting below saturation, the 16-step serial divider; input is taken only in
// the idle state, so a new word waits until the last one reaches the output register.
// Output register decouples the sides: next word is taken while a result waits.
// Reset: envelopes cleared, registers to defaults, output register empty.
// ----------------------------------------------------------------------------
module peak_limiter_gain_top #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [2:0] channel, [18:3] sample, [23:19] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // out_tdata: [15:0] gain_divisor, [31:16] envelope
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tuser: [0] limiting
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import plg_pkg::*;

  // only channels 0..7 are addressable
  localparam int DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state_r, state_nxt;

  logic [15:0] threshold_r, attack_r, release_r;
  logic [15:0] store_r [DEPTH];

  logic [IDX_W-1:0] idx_r;
  logic             ch_ok_r;
  logic [16:0]      mag_r;
  logic [15:0]      prev_r;
  logic [15:0]      env_r;
  logic             lim_r;
  logic [15:0]      div_r;

  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic        out_tuser_r;

  logic [2:0]        in_channel;
  logic [15:0]       in_sample;
  logic              in_acc;
  logic              ch_ok;
  logic [16:0]       mag;
  logic              cfg_wr;

  logic              mac_start, mac_done;
  logic signed [17:0] mac_diff;
  logic [15:0]       mac_coeff;
  logic signed [16:0] mac_prod;
  logic [17:0]       env_sum;
  logic [15:0]       env_new;

  logic              div_start, div_done;
  logic [15:0]       div_quot;
  logic              limit_now;
  logic              sat_now;
  logic              out_free;

  assign in_channel = in_tdata[2:0];
  assign in_sample  = in_tdata[18:3];
  assign in_acc     = in_tvalid && in_tready;
  assign ch_ok      = {4'b0000, in_channel} < 7'(CHANNELS);
  assign mag        = in_sample[15] ? (17'h10000 - {1'b0, in_sample}) : {1'b0, in_sample};

  assign mac_diff  = $signed({1'b0, mag_r}) - $signed({2'b00, prev_r});
  assign mac_coeff = (mag_r > {1'b0, prev_r}) ? attack_r : release_r;
  assign env_sum   = {2'b00, prev_r} + {mac_prod[16], mac_prod};
  assign env_new   = env_sum[15:0];

  assign limit_now = env_r > threshold_r;
  assign sat_now   = {8'h00, env_r} >= {threshold_r, 8'h00};
  assign out_free  = !out_tvalid_r || out_tready;

  plg_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mac_start),
    .coeff   (mac_coeff),
    .diff    (mac_diff),
    .done    (mac_done),
    .product (mac_prod)
  );

  plg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (env_r),
    .den   (threshold_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mac_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        mac_start = 1'b1;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (mac_done) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (limit_now && !sat_now) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r   <= in_channel[IDX_W-1:0];
      ch_ok_r <= ch_ok;
      mag_r   <= mag;
      prev_r  <= ch_ok ? store_r[in_channel[IDX_W-1:0]] : 16'h0000;
    end
    if (state_r == ST_MAC && mac_done) begin
      env_r <= env_new;
    end
    if (state_r == ST_EVAL) begin
      lim_r <= limit_now;
      div_r <= !limit_now ? DIV_UNITY : DIV_SAT;
    end
    if (state_r == ST_DIV && div_done) begin
      div_r <= div_quot;
    end
  end

  // envelope store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (state_r == ST_MAC && mac_done && ch_ok_r) begin
      store_r[idx_r] <= env_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_tdata_r <= {env_r, div_r};
      out_tuser_r <= lim_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_THRESHOLD: threshold_r <= cfg_pwdata[15:0];
        REG_ATTACK:    attack_r    <= cfg_pwdata[15:0];
        REG_RELEASE:   release_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_THRESHOLD: cfg_prdata = {16'h0000, threshold_r};
      REG_ATTACK:    cfg_prdata = {16'h0000, attack_r};
      REG_RELEASE:   cfg_prdata = {16'h0000, release_r};
      default:       cfg_prdata = 32'h0000_0000;
    endcase
  end

endmodule

>>> design/plg_mac.sv
// ----------------------------------------------------------------------------
// plg_mac: bit-serial coefficient multiplier
// Computes floor(coeff * diff / 65536), one coefficient bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module plg_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        coeff,
  input  logic signed [17:0] diff,
  output logic               done,
  output logic signed [16:0] product
);
  import plg_pkg::*;

  logic [15:0]        k_r, k_nxt;
  logic signed [17:0] d_r;
  logic signed [18:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               run_r;
  logic               done_r;

  logic signed [18:0] addend;
  logic signed [18:0] sum;

  always_comb begin
    addend  = k_r[0] ? {d_r[17], d_r} : '0;
    sum     = acc_r + addend;
    acc_nxt = sum >>> 1;
    k_nxt   = {1'b0, k_r[15:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r   <= coeff;
      d_r   <= diff;
      acc_r <= '0;
    end else if (run_r) begin
      k_r   <= k_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r[16:0];

endmodule

>>> design/plg_div.sv
// ----------------------------------------------------------------------------
// plg_div: restoring radix-2 divider
// Quotient of (num << 8) / den for a quotient known to fit 16 bits.
// ----------------------------------------------------------------------------
module plg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quot
);
  import plg_pkg::*;

  logic [15:0]      rem_r, rem_nxt;
  logic [15:0]      q_r, q_nxt;
  logic [15:0]      den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  // dividend bits leave q_r at the top as quotient bits enter at the bottom
  always_comb begin
    trial   = {rem_r, q_r[15]};
    diff    = trial - {1'b0, den_r};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff[15:0] : trial[15:0];
    q_nxt   = {q_r[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {8'h00, num[15:8]};
      q_r   <= {num[7:0], 8'h00};
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
